// ===== sv/gbc_pkg.sv =====
// Shared types and constants for the gyro bias calibration and correction block.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

    localparam int WORD_W          = 16;
    localparam int OFF_W           = 17;
    localparam int N_AXES          = 3;
    localparam int CAL_SAMPLES_DEF = 600;
    localparam int CAL_SKIP_DEF    = 6;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic signed [OFF_W-1:0] t_offset;

    typedef struct packed {
        logic sample;
        logic restart;
    } t_cal_ctl;

    typedef struct packed {
        logic busy;
        logic active;
    } t_cal_sts;

endpackage

`default_nettype wire

// ===== sv/gyro_bias_calibrate_correct_top.sv =====
// Top level of the gyro zero-rate bias calibration and correction block.
// Latency: a sample's result is registered at the edge of its transfer and can be taken next cycle.
// Throughput: one item per cycle while results are taken; a held result stalls the input.
// After the transfer that ends calibration, the input stalls while the offsets are
// computed by reciprocal multiplication.
// Synchronous reset empties the output register, zeroes offsets and starts calibrating.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_calibrate_correct_top #(
    parameter int CAL_SAMPLES = gbc_pkg::CAL_SAMPLES_DEF,
    parameter int CAL_SKIP    = gbc_pkg::CAL_SKIP_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_temp_word,
    input  wire logic [15:0] i_x_word,
    input  wire logic [15:0] i_y_word,
    input  wire logic [15:0] i_z_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [15:0] o_temperature,
    output logic signed [15:0] o_rate_x,
    output logic signed [15:0] o_rate_y,
    output logic signed [15:0] o_rate_z,
    output logic             o_calibrating
);

    gbc_pkg::t_cal_ctl ctl;
    gbc_pkg::t_cal_sts sts;
    gbc_pkg::t_word    axis [gbc_pkg::N_AXES];
    gbc_pkg::t_offset  offset [gbc_pkg::N_AXES];
    logic              accept;

    logic               r_valid;
    logic signed [15:0] r_temp;
    logic signed [15:0] r_rate [gbc_pkg::N_AXES];
    logic               r_cal;

    assign axis[0] = i_x_word;
    assign axis[1] = i_y_word;
    assign axis[2] = i_z_word;

    assign o_stall     = sts.busy || (r_valid && i_stall);
    assign accept      = i_valid && !o_stall;
    assign ctl.sample  = accept && (i_kind == gbc_pkg::KIND_SAMPLE);
    assign ctl.restart = accept && (i_kind == gbc_pkg::KIND_RESTART);

    gbc_cal #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .CAL_SKIP    (CAL_SKIP)
    ) u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_axis   (axis),
        .o_sts    (sts),
        .o_offset (offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= ctl.sample;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.sample) begin
            r_temp <= signed'(i_temp_word);
            r_cal  <= sts.active;
            for (int k = 0; k < gbc_pkg::N_AXES; k++) begin
                r_rate[k] <= signed'(axis[k] + offset[k][15:0]);
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_temperature = r_temp;
    assign o_rate_x      = r_rate[0];
    assign o_rate_y      = r_rate[1];
    assign o_rate_z      = r_rate[2];
    assign o_calibrating = r_cal;

    a_restart_calibrates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.restart |=> sts.active)
        else $error("restart did not start a calibration");

    a_busy_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !sts.active)
        else $error("offset computation running during calibration");

    a_no_transfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !accept)
        else $error("input transfer while offsets are computed");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_rate[0]) && $stable(r_temp)))
        else $error("pending result lost under stall");

endmodule

`default_nettype wire

// ===== sv/gbc_div.sv =====
// Division by a constant through multiplication by its reciprocal; the dividend, then the quotient, is registered.
`timescale 1ns / 1ps
`default_nettype none

module gbc_div #(
    parameter int W       = 26,
    parameter int DIVISOR = 594
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_quotient
);

    // The reciprocal is rounded up with W + clog2(DIVISOR) fraction bits, which makes the
    // quotient exact for every W-bit dividend.
    localparam int     LW    = $clog2(DIVISOR);
    localparam int     SHIFT = W + LW;
    localparam int     MW    = W + 1;
    localparam longint RECIP = ((longint'(1) <<< SHIFT) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

    logic            r_busy;
    logic            r_done;
    logic [W-1:0]    r_dvd;
    logic [W-1:0]    r_quo;

    logic [W+MW-1:0] prod;
    logic [W-1:0]    n_quo;

    always_comb begin
        prod  = r_dvd * RECIP_C;
        n_quo = W'(prod >> SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end
        if (r_busy) begin
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy || r_done;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== sv/gbc_cal.sv =====
// Calibration control: sample counting, per-axis sums and offset computation.
`timescale 1ns / 1ps
`default_nettype none

module gbc_cal #(
    parameter int CAL_SAMPLES = gbc_pkg::CAL_SAMPLES_DEF,
    parameter int CAL_SKIP    = gbc_pkg::CAL_SKIP_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire gbc_pkg::t_cal_ctl i_ctl,
    input  wire gbc_pkg::t_word  i_axis [gbc_pkg::N_AXES],
    output gbc_pkg::t_cal_sts o_sts,
    output gbc_pkg::t_offset  o_offset [gbc_pkg::N_AXES]
);

    localparam int CNTW = $clog2(CAL_SAMPLES + 1);
    localparam int SUMW = gbc_pkg::WORD_W + CNTW;
    localparam int DIV  = (CAL_SAMPLES > CAL_SKIP) ? (CAL_SAMPLES - CAL_SKIP) : 0;

    logic [CNTW-1:0]        r_count;
    logic                   r_active;
    logic signed [SUMW-1:0] r_sum [gbc_pkg::N_AXES];
    logic                   r_neg [gbc_pkg::N_AXES];
    gbc_pkg::t_offset       r_offset [gbc_pkg::N_AXES];

    logic [CNTW-1:0]        n_count;
    logic signed [SUMW-1:0] n_sum [gbc_pkg::N_AXES];
    logic [SUMW-1:0]        mag [gbc_pkg::N_AXES];
    logic                   step;
    logic                   sum_en;
    logic                   finish;
    logic [gbc_pkg::N_AXES-1:0] div_busy;
    logic [gbc_pkg::N_AXES-1:0] div_done;
    logic [SUMW-1:0]        quo [gbc_pkg::N_AXES];

    always_comb begin
        step    = i_ctl.sample && r_active;
        n_count = r_count + 1'b1;
        sum_en  = step && (int'(r_count) >= CAL_SKIP);
        finish  = step && (int'(n_count) >= CAL_SAMPLES);
        for (int k = 0; k < gbc_pkg::N_AXES; k++) begin
            n_sum[k] = r_sum[k] + SUMW'(signed'(i_axis[k]));
            mag[k]   = n_sum[k][SUMW-1] ? SUMW'(-n_sum[k]) : SUMW'(n_sum[k]);
        end
    end

    generate
        if (DIV > 0) begin : g_div
            for (genvar k = 0; k < gbc_pkg::N_AXES; k++) begin : g_lane
                gbc_div #(
                    .W       (SUMW),
                    .DIVISOR (DIV)
                ) u_div (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_start    (finish),
                    .i_dividend (mag[k]),
                    .o_busy     (div_busy[k]),
                    .o_done     (div_done[k]),
                    .o_quotient (quo[k])
                );
            end
        end else begin : g_nodiv
            assign div_busy = '0;
            assign div_done = '0;
            for (genvar k = 0; k < gbc_pkg::N_AXES; k++) begin : g_lane
                assign quo[k] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_count  <= '0;
            r_active <= 1'b1;
            for (int k = 0; k < gbc_pkg::N_AXES; k++) begin
                r_sum[k]    <= '0;
                r_offset[k] <= '0;
                r_neg[k]    <= 1'b0;
            end
        end else begin
            if (step) begin
                r_count <= n_count;
                if (finish) begin
                    r_active <= 1'b0;
                end
            end
            for (int k = 0; k < gbc_pkg::N_AXES; k++) begin
                if (sum_en) begin
                    r_sum[k] <= n_sum[k];
                end
                if (finish) begin
                    r_neg[k] <= n_sum[k][SUMW-1];
                end
                if (div_done[k]) begin
                    r_offset[k] <= r_neg[k] ? gbc_pkg::OFF_W'(quo[k])
                                            : -gbc_pkg::OFF_W'(quo[k]);
                end
            end
        end
    end

    assign o_sts.busy   = |div_busy;
    assign o_sts.active = r_active;
    assign o_offset     = r_offset;

endmodule

`default_nettype wire
